// File: src/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types, constants and decode tables for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int unsigned CapW   = 16;
  localparam int unsigned UnitW  = 16;
  localparam int unsigned AccumW = 21;
  localparam int unsigned DfaW   = 4;

  localparam logic [CapW-1:0]  CAP_RESET  = 16'd256;
  localparam logic [DfaW-1:0]  DFA_ACCEPT = 4'd0;
  localparam logic [DfaW-1:0]  DFA_REJECT = 4'd1;
  localparam logic [DfaW-1:0]  DFA_LAST   = 4'd8;
  localparam logic [UnitW-1:0] LEAD_BASE  = 16'hD7C0;  // 0xD800 - (0x10000 >> 10)
  localparam logic [5:0]       TRAIL_HI   = 6'b110111; // 0xDC00 >> 10

  typedef enum logic [1:0] {
    END_NORMAL    = 2'd0,
    END_INVALID   = 2'd1,
    END_FULL      = 2'd2,
    END_TRUNCATED = 2'd3
  } end_status_t;

  // One result item
  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             is_last;
    end_status_t      end_status;
  } result_t;

  // Per-string decode state
  typedef struct packed {
    logic [DfaW-1:0]   dfa_state;
    logic [AccumW-1:0] code_accum;
    logic [CapW-1:0]   units_left;
    logic              discarding;
  } str_state_t;

  // Results of one byte: count of valid results, then up to two of them
  typedef struct packed {
    logic [1:0] n_push;
    result_t    res0;
    result_t    res1;
  } step_out_t;

  // Transition rows, entry for class c at bits [4c+3:4c]
  localparam logic [47:0] NS_ROW0 = 48'h641117853210;
  localparam logic [47:0] NS_ROW1 = 48'h111111111111;
  localparam logic [47:0] NS_ROW2 = 48'h110101111101;
  localparam logic [47:0] NS_ROW3 = 48'h112121111121;
  localparam logic [47:0] NS_ROW4 = 48'h111121111111;
  localparam logic [47:0] NS_ROW5 = 48'h112111111121;
  localparam logic [47:0] NS_ROW6 = 48'h113131111111;
  localparam logic [47:0] NS_ROW7 = 48'h113131111131;
  localparam logic [47:0] NS_ROW8 = 48'h111111111131;

  function automatic logic [3:0] byte_class(input logic [7:0] b);
    logic [3:0] c;
    if (b <= 8'h7F)      c = 4'd0;
    else if (b <= 8'h8F) c = 4'd1;
    else if (b <= 8'h9F) c = 4'd9;
    else if (b <= 8'hBF) c = 4'd7;
    else if (b <= 8'hC1) c = 4'd8;
    else if (b <= 8'hDF) c = 4'd2;
    else if (b == 8'hE0) c = 4'd10;
    else if (b == 8'hED) c = 4'd4;
    else if (b <= 8'hEF) c = 4'd3;
    else if (b == 8'hF0) c = 4'd11;
    else if (b <= 8'hF3) c = 4'd6;
    else if (b == 8'hF4) c = 4'd5;
    else                 c = 4'd8;
    return c;
  endfunction

  function automatic logic [DfaW-1:0] next_state(input logic [DfaW-1:0] st,
                                                 input logic [3:0] cls);
    logic [47:0] row;
    logic [47:0] sh;
    case (st)
      4'd0:    row = NS_ROW0;
      4'd2:    row = NS_ROW2;
      4'd3:    row = NS_ROW3;
      4'd4:    row = NS_ROW4;
      4'd5:    row = NS_ROW5;
      4'd6:    row = NS_ROW6;
      4'd7:    row = NS_ROW7;
      4'd8:    row = NS_ROW8;
      default: row = NS_ROW1;
    endcase
    sh = row >> {cls, 2'b00};
    return sh[DfaW-1:0];
  endfunction

  function automatic str_state_t rearm(input logic [CapW-1:0] cap);
    str_state_t s;
    s.dfa_state  = DFA_ACCEPT;
    s.code_accum = '0;
    s.units_left = cap;
    s.discarding = 1'b0;
    return s;
  endfunction

endpackage

// File: src/u8u16_step.sv
// ----------------------------------------------------------------------------
// u8u16_step
// Decode one UTF-8 byte against the string state: next state and results.
// ----------------------------------------------------------------------------
module u8u16_step (
  input  u8u16_pkg::str_state_t      st,
  input  logic [7:0]                 in_byte,
  input  logic [u8u16_pkg::CapW-1:0] capacity,
  output u8u16_pkg::str_state_t      st_next,
  output u8u16_pkg::step_out_t       step_out
);
  import u8u16_pkg::*;

  logic [DfaW-1:0]   dfa_cur;
  logic [3:0]        cls;
  logic [7:0]        lead_mask;
  logic [AccumW-1:0] accum_new;
  logic [DfaW-1:0]   dfa_new;
  logic              is_nul;
  logic              is_bmp;
  result_t           term;

  assign is_nul    = (in_byte == 8'd0);
  assign dfa_cur   = (st.dfa_state > DFA_LAST) ? DFA_REJECT : st.dfa_state;
  assign cls       = byte_class(in_byte);
  assign lead_mask = 8'hFF >> cls;
  assign accum_new = (dfa_cur != DFA_ACCEPT)
                     ? {st.code_accum[AccumW-7:0], in_byte[5:0]}
                     : {13'd0, lead_mask & in_byte};
  assign dfa_new   = next_state(dfa_cur, cls);
  assign is_bmp    = (accum_new[AccumW-1:UnitW] == '0);

  always_comb begin
    st_next           = st;
    term.code_unit    = '0;
    term.is_last      = 1'b1;
    term.end_status   = END_NORMAL;
    step_out.n_push   = 2'd0;
    step_out.res0     = term;
    step_out.res1     = term;
    if (st.discarding) begin
      // drop everything until NUL
      if (is_nul) begin
        st_next = rearm(capacity);
      end
    end else if (is_nul) begin
      step_out.n_push          = 2'd1;
      step_out.res0.end_status = (st.dfa_state == DFA_ACCEPT) ? END_NORMAL : END_TRUNCATED;
      st_next                  = rearm(capacity);
    end else if (st.units_left <= 16'd1) begin
      step_out.n_push          = 2'd1;
      step_out.res0.end_status = END_FULL;
      st_next.discarding       = 1'b1;
    end else begin
      st_next.dfa_state  = dfa_new;
      st_next.code_accum = accum_new;
      if (dfa_new == DFA_REJECT) begin
        step_out.n_push          = 2'd1;
        step_out.res0.end_status = END_INVALID;
        st_next.discarding       = 1'b1;
      end else if (dfa_new == DFA_ACCEPT) begin
        if (is_bmp) begin
          step_out.n_push         = 2'd1;
          step_out.res0.code_unit = accum_new[UnitW-1:0];
          step_out.res0.is_last   = 1'b0;
          st_next.units_left      = st.units_left - 16'd1;
        end else if (st.units_left > 16'd2) begin
          step_out.n_push         = 2'd2;
          step_out.res0.code_unit = LEAD_BASE + {5'd0, accum_new[AccumW-1:10]};
          step_out.res0.is_last   = 1'b0;
          step_out.res1.code_unit = {TRAIL_HI, accum_new[9:0]};
          step_out.res1.is_last   = 1'b0;
          st_next.units_left      = st.units_left - 16'd2;
        end else begin
          step_out.n_push          = 2'd1;
          step_out.res0.end_status = END_FULL;
          st_next.discarding       = 1'b1;
        end
      end
    end
  end

endmodule

// File: src/u8u16_queue.sv
// ----------------------------------------------------------------------------
// u8u16_queue
// Four-entry result queue: takes up to two requests per cycle, gives one.
// ----------------------------------------------------------------------------
module u8u16_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_n,
  input  u8u16_pkg::result_t  push0,
  input  u8u16_pkg::result_t  push1,
  input  logic                pop,
  output u8u16_pkg::result_t  head,
  output logic                not_empty,
  output logic                almost_full,
  output logic [2:0]          level
);
  import u8u16_pkg::*;

  result_t    slots [4];
  logic [1:0] rd_ptr;
  logic [1:0] wr_ptr;
  logic [1:0] wr_ptr1;
  logic [2:0] count;
  logic [2:0] count_next;

  assign wr_ptr1     = wr_ptr + 2'd1;
  assign head        = slots[rd_ptr];
  assign not_empty   = (count != 3'd0);
  assign almost_full = (count > 3'd2);
  assign level       = count;
  assign count_next  = count + {1'b0, push_n} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      slots[wr_ptr] <= push0;
    end
    if (push_n == 2'd2) begin
      slots[wr_ptr1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count_next;
    end
  end

endmodule

// File: src/utf8_to_utf16be_transcoder_top.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16be_transcoder_top
// UTF-8 byte stream in, UTF-16 code units with a flagged terminator out.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall / in_byte): one UTF-8 byte per request.
//   A zero byte ends the string.
//   Output channel (out_valid / out_stall / code_unit, is_last, end_status):
//   one UTF-16 code unit per request; each string closes with a zero unit
//   flagged is_last, whose end_status tells normal end, invalid sequence,
//   buffer full or truncated sequence.
//   Configuration channel (cfg_valid / cfg_ready / capacity_units): sets the
//   buffer size in units, terminator included, and rearms the string state.
//   cfg_ready is always high; write only while the block is idle.
//   Latency: results of a byte are offered at the earliest the cycle after it
//   is accepted, behind any requests already queued.
//   Throughput: one byte per cycle while in_stall is low. A supplementary
//   code point gives a surrogate pair and so takes two output requests.
//   The bytes are decoded at acceptance and the results land in a four-entry
//   queue; in_stall rises when fewer than two entries are free, so a stalled
//   receiver holds back the sender once three requests wait. Bytes that give
//   no request (continuation bytes, discarded bytes) are held back as well.
//   Reset: queue empty, capacity 256, decoder in its accept state.
// ----------------------------------------------------------------------------
module utf8_to_utf16be_transcoder_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [u8u16_pkg::UnitW-1:0] code_unit,
  output logic                        is_last,
  output logic [1:0]                  end_status,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [u8u16_pkg::CapW-1:0]  capacity_units
);
  import u8u16_pkg::*;

  logic [CapW-1:0] capacity;
  str_state_t      str_state;
  str_state_t      str_state_next;
  step_out_t       step_out;
  result_t         head;
  logic            in_take;
  logic            out_take;
  logic            cfg_take;
  logic            q_not_empty;
  logic            q_almost_full;
  logic [2:0]      q_level;
  logic [1:0]      push_n;

  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid & cfg_ready;
  assign in_stall  = q_almost_full;
  assign in_take   = in_valid & ~in_stall;
  assign out_valid = q_not_empty;
  assign out_take  = out_valid & ~out_stall;

  // decode the byte presented on the input against the current string state
  u8u16_step u_step (
    .st       (str_state),
    .in_byte  (in_byte),
    .capacity (capacity),
    .st_next  (str_state_next),
    .step_out (step_out)
  );

  // only an accepted byte produces requests
  assign push_n = in_take ? step_out.n_push : 2'd0;

  u8u16_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push_n      (push_n),
    .push0       (step_out.res0),
    .push1       (step_out.res1),
    .pop         (out_take),
    .head        (head),
    .not_empty   (q_not_empty),
    .almost_full (q_almost_full),
    .level       (q_level)
  );

  assign code_unit  = head.code_unit;
  assign is_last    = head.is_last;
  assign end_status = head.end_status;

  // capacity write rearms the string; otherwise advance on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      str_state <= rearm(CAP_RESET);
    end else if (cfg_take) begin
      capacity  <= capacity_units;
      str_state <= rearm(capacity_units);
    end else if (in_take) begin
      str_state <= str_state_next;
    end
  end

  // units left never exceed the configured capacity
  a_units_bound: assert property (@(posedge clk) disable iff (rst)
    str_state.units_left <= capacity)
    else $error("units_left above capacity");

  // queue never overflows
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_level <= 3'd4)
    else $error("result queue overflow");

  // an accepted byte always finds room for two requests
  a_room: assert property (@(posedge clk) disable iff (rst)
    in_take |-> q_level <= 3'd2)
    else $error("byte accepted without room");

  // a terminator carries a zero unit
  a_term_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_last) |-> code_unit == '0)
    else $error("terminator with non-zero unit");

  // while discarding, no requests are produced
  a_discard_silent: assert property (@(posedge clk) disable iff (rst)
    (in_take && str_state.discarding) |-> push_n == 2'd0)
    else $error("output while discarding");

endmodule

// File: bench/u8u16_checker.sv
// ----------------------------------------------------------------------------
// u8u16_checker
// Watches the transcoder's channels, predicts every code unit and terminator
// from the accepted bytes and capacity writes, and compares in order.
// ----------------------------------------------------------------------------
module u8u16_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [7:0]                  in_byte,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [u8u16_pkg::UnitW-1:0] code_unit,
  input  logic                        is_last,
  input  logic [1:0]                  end_status,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [u8u16_pkg::CapW-1:0]  capacity_units,
  output int                          mismatches,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import u8u16_pkg::*;

  localparam logic [UnitW-1:0] LOW_SURR_BASE = 16'hDC00;

  // next decoder state, indexed by current state then byte class
  localparam logic [3:0] DFA_NEXT [9][12] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
  };

  logic [CapW-1:0]   capacity;
  logic [DfaW-1:0]   dec_state;
  logic [AccumW-1:0] cp_accum;
  logic [CapW-1:0]   free_units;
  logic              dropping;
  result_t           units_due [$];
  int                errors = 0;

  assign mismatches = errors;

  function automatic logic [3:0] utf8_class(input logic [7:0] b);
    logic [3:0] cls;
    case (b[7:4])
      4'h8:        cls = 4'd1;
      4'h9:        cls = 4'd9;
      4'hA, 4'hB:  cls = 4'd7;
      4'hC:        cls = (b[3:1] == 3'b000) ? 4'd8 : 4'd2;
      4'hD:        cls = 4'd2;
      4'hE: begin
        if (b[3:0] == 4'h0)      cls = 4'd10;
        else if (b[3:0] == 4'hD) cls = 4'd4;
        else                     cls = 4'd3;
      end
      4'hF: begin
        if (b[3:0] == 4'h0)      cls = 4'd11;
        else if (b[3:0] <= 4'h3) cls = 4'd6;
        else if (b[3:0] == 4'h4) cls = 4'd5;
        else                     cls = 4'd8;
      end
      default:     cls = 4'd0;
    endcase
    return cls;
  endfunction

  task automatic restart_string();
    dec_state  = DFA_ACCEPT;
    cp_accum   = '0;
    free_units = capacity;
    dropping   = 1'b0;
  endtask

  task automatic post_unit(input logic [UnitW-1:0] unit, input logic last,
                           input end_status_t status);
    result_t r;
    r.code_unit  = unit;
    r.is_last    = last;
    r.end_status = status;
    units_due.push_back(r);
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [3:0] cls;
    logic [3:0] st;
    logic [7:0] lead_bits;
    if (dropping) begin
      if (b == 8'h00) restart_string();
      return;
    end
    if (b == 8'h00) begin
      post_unit('0, 1'b1, (dec_state == DFA_ACCEPT) ? END_NORMAL : END_TRUNCATED);
      restart_string();
      return;
    end
    if (free_units <= 1) begin
      post_unit('0, 1'b1, END_FULL);
      dropping = 1'b1;
      return;
    end
    st  = (dec_state > DFA_LAST) ? DFA_REJECT : dec_state;
    cls = utf8_class(b);
    if (st != DFA_ACCEPT) begin
      cp_accum = {cp_accum[AccumW-7:0], b[5:0]};
    end else begin
      lead_bits = (8'hFF >> cls) & b;
      cp_accum  = {13'b0, lead_bits};
    end
    st        = DFA_NEXT[st][cls];
    dec_state = st;
    if (st == DFA_REJECT) begin
      post_unit('0, 1'b1, END_INVALID);
      dropping = 1'b1;
    end else if (st == DFA_ACCEPT) begin
      if (cp_accum <= 21'h00FFFF) begin
        post_unit(cp_accum[15:0], 1'b0, END_NORMAL);
        free_units = free_units - 1'b1;
      end else if (free_units > 2) begin
        post_unit(LEAD_BASE + {5'b0, cp_accum[20:10]}, 1'b0, END_NORMAL);
        post_unit(LOW_SURR_BASE + {6'b0, cp_accum[9:0]}, 1'b0, END_NORMAL);
        free_units = free_units - 2'd2;
      end else begin
        post_unit('0, 1'b1, END_FULL);
        dropping = 1'b1;
      end
    end
  endtask

  task automatic check_unit();
    result_t want;
    if (units_due.size() == 0) begin
      $error("code_unit: expected nothing, actual %h", code_unit);
      errors++;
      return;
    end
    want = units_due.pop_front();
    if (code_unit !== want.code_unit) begin
      $error("code_unit: expected %h, actual %h", want.code_unit, code_unit);
      errors++;
    end
    if (is_last !== want.is_last) begin
      $error("is_last: expected %b, actual %b", want.is_last, is_last);
      errors++;
    end
    if (end_status !== want.end_status) begin
      $error("end_status: expected %0d, actual %0d", want.end_status, end_status);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      capacity = CAP_RESET;
      restart_string();
      units_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity = capacity_units;
        restart_string();
      end
      if (in_valid && !in_stall) decode_byte(in_byte);
      if (out_valid && !out_stall) check_unit();
    end
    pending <= units_due.size();
  end

endmodule

// File: bench/utf8_to_utf16be_transcoder_top_tb.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16be_transcoder_top_tb
// Drives UTF-8 strings into the transcoder under a run of buffer capacities
// and idling mixes; a checker beside the block predicts and compares every
// unit and terminator, and this module gives the verdict.
// ----------------------------------------------------------------------------
module utf8_to_utf16be_transcoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import u8u16_pkg::*;

  // Hand-picked bytes at the default capacity: one-, three- and four-byte
  // characters up to the top code point, a string cut short by NUL, and a
  // surrogate encoding that is rejected with the rest dropped until NUL.
  localparam logic [7:0] OPENING [16] = '{
    8'h41, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h00,
    8'hE2, 8'h82, 8'h00,
    8'hED, 8'hA0, 8'hFF, 8'h00
  };
  // Capacity 3: a surrogate pair fits, then the next character finds it full.
  localparam logic [7:0] PAIR_THEN_FULL [6] = '{
    8'hF0, 8'h9F, 8'h98, 8'h80, 8'h41, 8'h00
  };
  // Capacity 2: NUL on a full buffer ends normally; a pair cannot fit.
  localparam logic [7:0] NO_ROOM_FOR_PAIR [7] = '{
    8'h41, 8'h00, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h00
  };

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [7:0]          in_byte;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [UnitW-1:0]    code_unit;
  logic                is_last;
  logic [1:0]          end_status;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CapW-1:0]     capacity_units;

  int                  mismatches;
  int                  pending;
  int                  bytes_sent  = 0;
  int                  tx_idle_pct = 0;
  int                  stall_pct   = 0;
  bit                  rx_hold     = 1'b0;

  utf8_to_utf16be_transcoder_top uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .code_unit      (code_unit),
    .is_last        (is_last),
    .end_status     (end_status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .capacity_units (capacity_units)
  );

  u8u16_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .code_unit      (code_unit),
    .is_last        (is_last),
    .end_status     (end_status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .capacity_units (capacity_units),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: stall at random, or hold off completely while a long stall is
  // requested. The knobs only change at a rising edge, so the falling-edge
  // read is never racing them.
  always @(negedge clk) begin
    if (rx_hold) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offer one byte, with random idle cycles ahead of it, and hold it until
  // the request is taken. Leave valid high on return so that a following
  // byte goes out back to back.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      in_byte  <= 8'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Encode one code point as UTF-8; optionally drop its tail bytes so that
  // the sequence is left unfinished.
  task automatic send_code_point(input logic [20:0] cp, input bit cut_short);
    logic [7:0] seq [4];
    int         len;
    int         upto;
    if (cp < 21'h80) begin
      seq[0] = cp[7:0];
      len    = 1;
    end else if (cp < 21'h800) begin
      seq[0] = {3'b110, cp[10:6]};
      seq[1] = {2'b10, cp[5:0]};
      len    = 2;
    end else if (cp < 21'h10000) begin
      seq[0] = {4'b1110, cp[15:12]};
      seq[1] = {2'b10, cp[11:6]};
      seq[2] = {2'b10, cp[5:0]};
      len    = 3;
    end else begin
      seq[0] = {5'b11110, cp[20:18]};
      seq[1] = {2'b10, cp[17:12]};
      seq[2] = {2'b10, cp[11:6]};
      seq[3] = {2'b10, cp[5:0]};
      len    = 4;
    end
    upto = (cut_short && len > 1) ? $urandom_range(len - 1, 1) : len;
    for (int i = 0; i < upto; i++) send_byte(seq[i]);
  endtask

  // Mostly well-formed strings with random characters of every length, with
  // a sprinkling of stray bytes, cut sequences and strings left without NUL.
  task automatic send_random_string();
    int          chars;
    logic [20:0] cp;
    chars = $urandom_range(6);
    repeat (chars) begin
      if ($urandom_range(99) < 8) begin
        send_byte(8'($urandom_range(255)));
      end else begin
        case ($urandom_range(3))
          0:       cp = 21'($urandom_range(127, 1));
          1:       cp = 21'($urandom_range(16'h07FF, 16'h0080));
          2:       cp = 21'($urandom_range(16'hFFFF, 16'h0800));
          default: cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
        endcase
        send_code_point(cp, $urandom_range(99) < 6);
      end
    end
    if ($urandom_range(99) < 92) send_byte(8'h00);
  endtask

  // Drop valid, wait until every predicted unit has come back and let the
  // block settle, then set the idling mix and write a new capacity.
  task automatic start_phase(input logic [CapW-1:0] cap, input int tx_pct,
                             input int rx_pct);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    tx_idle_pct = tx_pct;
    stall_pct   = rx_pct;
    @(negedge clk);
    cfg_valid      <= 1'b1;
    capacity_units <= cap;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold the receiver off for the stretch given by the argument, so the result
  // queue fills and the block pushes back on its input.
  task automatic hold_receiver(input int cycles);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold = 1'b0;
    @(negedge clk);
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_byte        = 8'h00;
    cfg_valid      = 1'b0;
    capacity_units = CAP_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed requests at the reset capacity, then the tiny buffers.
    foreach (OPENING[i]) send_byte(OPENING[i]);
    start_phase(16'd3, 0, 0);
    foreach (PAIR_THEN_FULL[i]) send_byte(PAIR_THEN_FULL[i]);
    start_phase(16'd2, 0, 0);
    foreach (NO_ROOM_FOR_PAIR[i]) send_byte(NO_ROOM_FOR_PAIR[i]);

    // Largest buffer, no idling, with one long receiver hold-off while the
    // sender keeps pushing.
    start_phase(16'hFFFF, 0, 0);
    fork
      hold_receiver(250);
      begin
        while (bytes_sent < 90) send_random_string();
        in_valid <= 1'b0;
        @(negedge clk);
      end
    join

    start_phase(16'd4, 82, 0);
    while (bytes_sent < 150) send_random_string();
    start_phase(16'd2, 0, 82);
    while (bytes_sent < 210) send_random_string();
    start_phase(16'd1, 24, 24);
    while (bytes_sent < 230) send_random_string();
    start_phase(16'd0, 24, 24);
    while (bytes_sent < 245) send_random_string();
    start_phase(16'd9, 24, 24);
    while (bytes_sent < 310) send_random_string();
    start_phase(16'd300, 0, 0);
    while (bytes_sent < 370) send_random_string();

    // Drain: wait for every predicted unit, then keep watching for anything
    // spurious.
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Backstop against a hung handshake.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
